// ----- src/priority_message_queue_macros.svh -----
// Assertion macros shared by the priority message queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmq assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmq assertion failed");
`else
`define PMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/pmq_pkg.sv -----
// Package for the priority message queue: payload structs, codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
package pmq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIORITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE     = 2'd2;

  localparam logic [4:0] CAPACITY_RST     = 5'd16;
  localparam logic [7:0] MAX_PRIORITY_RST = 8'd255;
  localparam logic [3:0] MAX_SIZE_RST     = 4'd8;

  localparam logic [1:0] FUNC_SEND  = 2'd0;
  localparam logic [1:0] FUNC_RECV  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPAR = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] payload;
    logic [3:0]  msg_size;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_payload;
    logic [3:0]  out_size;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_RD,
    S_ALLOC,
    S_WALK_RD,
    S_WALK_CMP,
    S_LINK_NEW,
    S_LINK_PREV,
    S_RECV_RD,
    S_RECV_DONE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       status_we;
    logic [1:0] status;
    logic       clear_q;
    logic       free_rd;
    logic       alloc;
    logic       walk_rd;
    logic       walk_step;
    logic       link_new;
    logic       link_prev;
    logic       recv_rd;
    logic       recv_done;
    logic       resp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bad_par;
    logic       full;
    logic       empty;
    logic       free_avail;
    logic       walk_more;
    logic       walk_go;
    logic       prev_none;
    logic       out_free;
  } sts_t;

endpackage

// ----- src/pmq_ctrl.sv -----
// Controller state machine of the priority message queue.
// Depends on pmq_pkg for the state enum and the command/status structs.
module pmq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pmq_pkg::sts_t  sts,
  output pmq_pkg::cmd_t  cmd
);

  pmq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pmq_pkg::S_DECODE;
        end
      end
      pmq_pkg::S_DECODE: begin
        unique case (sts.func)
          pmq_pkg::FUNC_SEND: begin
            if (sts.bad_par || sts.full) begin
              state_nxt = pmq_pkg::S_RESP;
            end else if (sts.free_avail) begin
              state_nxt = pmq_pkg::S_FREE_RD;
            end else begin
              state_nxt = pmq_pkg::S_ALLOC;
            end
          end
          pmq_pkg::FUNC_RECV: begin
            state_nxt = sts.empty ? pmq_pkg::S_RESP : pmq_pkg::S_RECV_RD;
          end
          default: begin
            state_nxt = pmq_pkg::S_RESP;
          end
        endcase
      end
      pmq_pkg::S_FREE_RD:   state_nxt = pmq_pkg::S_ALLOC;
      pmq_pkg::S_ALLOC:     state_nxt = pmq_pkg::S_WALK_RD;
      pmq_pkg::S_WALK_RD: begin
        state_nxt = sts.walk_more ? pmq_pkg::S_WALK_CMP : pmq_pkg::S_LINK_NEW;
      end
      pmq_pkg::S_WALK_CMP: begin
        state_nxt = sts.walk_go ? pmq_pkg::S_WALK_RD : pmq_pkg::S_LINK_NEW;
      end
      pmq_pkg::S_LINK_NEW: begin
        state_nxt = sts.prev_none ? pmq_pkg::S_RESP : pmq_pkg::S_LINK_PREV;
      end
      pmq_pkg::S_LINK_PREV: state_nxt = pmq_pkg::S_RESP;
      pmq_pkg::S_RECV_RD:   state_nxt = pmq_pkg::S_RECV_DONE;
      pmq_pkg::S_RECV_DONE: state_nxt = pmq_pkg::S_RESP;
      pmq_pkg::S_RESP: begin
        if (sts.out_free) begin
          state_nxt = pmq_pkg::S_IDLE;
        end
      end
      default: state_nxt = pmq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      pmq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pmq_pkg::S_DECODE: begin
        cmd.status_we = 1'b1;
        unique case (sts.func)
          pmq_pkg::FUNC_SEND: begin
            priority if (sts.bad_par) begin
              cmd.status = pmq_pkg::ST_BADPAR;
            end else if (sts.full) begin
              cmd.status = pmq_pkg::ST_FULL;
            end else begin
              cmd.status = pmq_pkg::ST_OK;
            end
          end
          pmq_pkg::FUNC_RECV: begin
            cmd.status = sts.empty ? pmq_pkg::ST_EMPTY : pmq_pkg::ST_OK;
          end
          pmq_pkg::FUNC_CLEAR: begin
            cmd.status  = pmq_pkg::ST_OK;
            cmd.clear_q = 1'b1;
          end
          default: begin
            cmd.status = pmq_pkg::ST_BADPAR;
          end
        endcase
      end
      pmq_pkg::S_FREE_RD:   cmd.free_rd   = 1'b1;
      pmq_pkg::S_ALLOC:     cmd.alloc     = 1'b1;
      pmq_pkg::S_WALK_RD:   cmd.walk_rd   = sts.walk_more;
      pmq_pkg::S_WALK_CMP:  cmd.walk_step = sts.walk_go;
      pmq_pkg::S_LINK_NEW:  cmd.link_new  = 1'b1;
      pmq_pkg::S_LINK_PREV: cmd.link_prev = 1'b1;
      pmq_pkg::S_RECV_RD:   cmd.recv_rd   = 1'b1;
      pmq_pkg::S_RECV_DONE: cmd.recv_done = 1'b1;
      pmq_pkg::S_RESP:      cmd.resp      = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/pmq_dp.sv -----
// Datapath of the priority message queue: configuration, entry memories,
// linked-list pointers, insert walk and output register. Depends on pmq_pkg.
`include "priority_message_queue_macros.svh"

module pmq_dp #(
  parameter int DEPTH         = pmq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BYTES = pmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pmq_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pmq_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  pmq_pkg::cmd_t                    cmd,
  output pmq_pkg::sts_t                    sts
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LINK_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int PW     = 8 * PAYLOAD_BYTES;
  localparam logic [LINK_W-1:0] NONE_IDX = LINK_W'(DEPTH);

  // Configuration registers.
  logic [4:0] capacity_r, capacity_nxt;
  logic [7:0] max_pri_r, max_pri_nxt;
  logic [3:0] max_size_r, max_size_nxt;

  // Queue control state.
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;

  // Insert walk state.
  logic [LINK_W-1:0] prev_r, prev_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  visited_r, visited_nxt;
  logic [IDX_W-1:0]  e_r, e_nxt;

  // Captured item and result fields.
  pmq_pkg::in_item_t item_r;
  logic [1:0]  res_status_r;
  logic [PW-1:0] res_pay_r;
  logic [3:0]  res_size_r;
  logic [7:0]  res_pri_r;

  logic               out_valid_r, out_valid_nxt;
  pmq_pkg::out_item_t out_data_r;

  // Entry memories.
  logic [PW-1:0]     pay_mem  [DEPTH];
  logic [3:0]        size_mem [DEPTH];
  logic [7:0]        pri_mem  [DEPTH];
  logic [LINK_W-1:0] link_mem [DEPTH];

  logic [PW-1:0]     pay_rd_r;
  logic [3:0]        size_rd_r;
  logic [7:0]        pri_rd_r;
  logic [LINK_W-1:0] link_rd_r;

  logic              pri_re, link_re, link_we;
  logic [IDX_W-1:0]  pri_raddr, link_raddr, link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic [IDX_W-1:0]  e_sel;
  logic [PW-1:0]     pay_masked;
  logic              free_avail;

  assign free_avail = (free_head_r < NONE_IDX);
  assign e_sel      = free_avail ? free_head_r[IDX_W-1:0] : fresh_r[IDX_W-1:0];

  // Bytes above the message size are never stored.
  always_comb begin
    pay_masked = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (4'(i) < item_r.msg_size) begin
        pay_masked[i*8 +: 8] = item_r.payload[i*8 +: 8];
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.func       = item_r.func;
    sts.bad_par    = (item_r.priority_req == 8'd0) || (item_r.priority_req > max_pri_r)
                     || (item_r.msg_size > max_size_r)
                     || (item_r.msg_size > 4'(PAYLOAD_BYTES));
    sts.full       = (CMP_W'(held_r) >= CMP_W'(capacity_r)) || (held_r == CNT_W'(DEPTH));
    sts.empty      = (held_r == '0);
    sts.free_avail = free_avail;
    sts.walk_more  = (visited_r < held_r) && (cur_r < NONE_IDX);
    sts.walk_go    = (pri_rd_r <= item_r.priority_req);
    sts.prev_none  = (prev_r == NONE_IDX);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Memory port selection.
  always_comb begin
    pri_re     = cmd.walk_rd || cmd.recv_rd;
    pri_raddr  = cmd.recv_rd ? head_r : cur_r[IDX_W-1:0];
    link_re    = cmd.free_rd || cmd.walk_rd || cmd.recv_rd;
    priority if (cmd.free_rd) begin
      link_raddr = free_head_r[IDX_W-1:0];
    end else if (cmd.walk_rd) begin
      link_raddr = cur_r[IDX_W-1:0];
    end else begin
      link_raddr = head_r;
    end
    link_we    = cmd.recv_done || cmd.link_new || cmd.link_prev;
    priority if (cmd.recv_done) begin
      link_waddr = head_r;
      link_wdata = free_head_r;
    end else if (cmd.link_new) begin
      link_waddr = e_r;
      link_wdata = (visited_r < held_r) ? cur_r : NONE_IDX;
    end else begin
      link_waddr = prev_r[IDX_W-1:0];
      link_wdata = LINK_W'(e_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      pay_mem[e_sel]  <= pay_masked;
      size_mem[e_sel] <= item_r.msg_size;
      pri_mem[e_sel]  <= item_r.priority_req;
    end
    if (cmd.recv_rd) begin
      pay_rd_r  <= pay_mem[head_r];
      size_rd_r <= size_mem[head_r];
    end
    if (pri_re) begin
      pri_rd_r <= pri_mem[pri_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  // Next values of control and walk state.
  always_comb begin
    capacity_nxt  = capacity_r;
    max_pri_nxt   = max_pri_r;
    max_size_nxt  = max_size_r;
    head_nxt      = head_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    held_nxt      = held_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    visited_nxt   = visited_r;
    e_nxt         = e_r;

    if (cfg_we) begin
      unique case (cfg_index)
        pmq_pkg::CFG_CAPACITY:     capacity_nxt = cfg_wdata[4:0];
        pmq_pkg::CFG_MAX_PRIORITY: max_pri_nxt  = cfg_wdata[7:0];
        pmq_pkg::CFG_MAX_SIZE:     max_size_nxt = cfg_wdata[3:0];
        default: begin
          capacity_nxt = capacity_r;
        end
      endcase
    end

    if (cmd.clear_q) begin
      head_nxt      = '0;
      free_head_nxt = NONE_IDX;
      fresh_nxt     = '0;
      held_nxt      = '0;
    end
    if (cmd.alloc) begin
      e_nxt = e_sel;
      if (free_avail) begin
        free_head_nxt = link_rd_r;
      end else begin
        fresh_nxt = fresh_r + CNT_W'(1);
      end
      prev_nxt    = NONE_IDX;
      cur_nxt     = LINK_W'(head_r);
      visited_nxt = '0;
    end
    if (cmd.walk_step) begin
      prev_nxt    = cur_r;
      cur_nxt     = link_rd_r;
      visited_nxt = visited_r + CNT_W'(1);
    end
    if (cmd.link_new) begin
      held_nxt = held_r + CNT_W'(1);
      if (prev_r == NONE_IDX) begin
        head_nxt = e_r;
      end
    end
    if (cmd.recv_done) begin
      held_nxt      = held_r - CNT_W'(1);
      head_nxt      = (held_r > CNT_W'(1)) ? link_rd_r[IDX_W-1:0] : '0;
      free_head_nxt = LINK_W'(head_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= pmq_pkg::CAPACITY_RST;
      max_pri_r   <= pmq_pkg::MAX_PRIORITY_RST;
      max_size_r  <= pmq_pkg::MAX_SIZE_RST;
      head_r      <= '0;
      free_head_r <= NONE_IDX;
      fresh_r     <= '0;
      held_r      <= '0;
      prev_r      <= NONE_IDX;
      cur_r       <= NONE_IDX;
      visited_r   <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      max_pri_r   <= max_pri_nxt;
      max_size_r  <= max_size_nxt;
      head_r      <= head_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      held_r      <= held_nxt;
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      visited_r   <= visited_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid_nxt = cmd.resp ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Item, result and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r       <= in_data;
      res_status_r <= pmq_pkg::ST_OK;
      res_pay_r    <= '0;
      res_size_r   <= '0;
      res_pri_r    <= '0;
    end
    if (cmd.status_we) begin
      res_status_r <= cmd.status;
    end
    if (cmd.recv_done) begin
      res_pay_r  <= pay_rd_r;
      res_size_r <= size_rd_r;
      res_pri_r  <= pri_rd_r;
    end
    if (cmd.resp) begin
      out_data_r.status       <= res_status_r;
      out_data_r.out_payload  <= 64'(res_pay_r);
      out_data_r.out_size     <= res_size_r;
      out_data_r.out_priority <= res_pri_r;
      out_data_r.occupancy    <= 5'(held_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PMQ_ASSERT_IMPL(a_held_bounded, clk, rst_n, 1'b1, held_r <= CNT_W'(DEPTH))
  `PMQ_ASSERT_IMPL(a_fresh_in_range, clk, rst_n, cmd.alloc && !free_avail, fresh_r < CNT_W'(DEPTH))
  `PMQ_ASSERT_IMPL(a_recv_not_empty, clk, rst_n, cmd.recv_done, held_r != '0)
  `PMQ_ASSERT_NEXT(a_walk_bounded, clk, rst_n, cmd.walk_step, visited_r <= held_r)
  `PMQ_ASSERT_NEXT(a_insert_count, clk, rst_n, cmd.link_new, held_r == $past(held_r) + CNT_W'(1))

endmodule

// ----- src/priority_message_queue.sv -----
// Priority message queue top level. Each input transfer is decoded; clear and rejected items
// then go to the result, a receive reads and unlinks the head entry, and a send reuses a
// released entry if there is one, walks past each held message whose priority value is not
// above its own and links in; the one read port of the entry memories sets the walk pace.
// One item at a time: the next transfer comes in the cycle after the result is loaded, later
// while the receiver stalls. Synchronous reset empties the queue and restores the settings.
module priority_message_queue #(
  parameter int DEPTH         = pmq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BYTES = pmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pmq_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pmq_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  pmq_pkg::cmd_t cmd;
  pmq_pkg::sts_t sts;

  pmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmq_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for priority_message_queue: random and directed queue operations
// are checked against a behavioral model of the sorted queue kept in the testbench.
// Depends on pmq_pkg and the priority_message_queue RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  size;
    logic [7:0]  prio;
  } held_msg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pmq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pmq_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [pmq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pmq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model of the queue contents and configuration.
  held_msg_t held_msgs[$];
  logic [4:0] capacity_reg = pmq_pkg::CAPACITY_RST;
  logic [7:0] max_prio_reg = pmq_pkg::MAX_PRIORITY_RST;
  logic [3:0] max_size_reg = pmq_pkg::MAX_SIZE_RST;

  pmq_pkg::in_item_t pending_ops[$];
  pmq_pkg::out_item_t expected_results[$];
  int items_queued = 0;
  int items_accepted = 0;
  int mismatches = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int rx_hold = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  priority_message_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic pmq_pkg::out_item_t predict_queue_op(pmq_pkg::in_item_t op);
    pmq_pkg::out_item_t res;
    held_msg_t msg;
    int size_lim;
    int cap;
    int pos;
    res = '0;
    size_lim = (max_size_reg < pmq_pkg::PAYLOAD_BYTES_DEF) ? max_size_reg
                                                           : pmq_pkg::PAYLOAD_BYTES_DEF;
    cap = (capacity_reg < pmq_pkg::DEPTH_DEF) ? capacity_reg : pmq_pkg::DEPTH_DEF;
    unique case (op.func)
      pmq_pkg::FUNC_SEND: begin
        if (op.priority_req == 8'd0 || op.priority_req > max_prio_reg ||
            op.msg_size > size_lim) begin
          res.status = pmq_pkg::ST_BADPAR;
        end else if (held_msgs.size() >= cap) begin
          res.status = pmq_pkg::ST_FULL;
        end else begin
          msg.data = op.payload & ((op.msg_size >= 4'd8) ? {64{1'b1}} :
                                   ((64'd1 << (8 * op.msg_size)) - 64'd1));
          msg.size = op.msg_size;
          msg.prio = op.priority_req;
          // Equal priorities keep arrival order: go behind every entry not above ours.
          pos = 0;
          while (pos < held_msgs.size() && held_msgs[pos].prio <= op.priority_req) pos++;
          held_msgs.insert(pos, msg);
          res.status = pmq_pkg::ST_OK;
        end
      end
      pmq_pkg::FUNC_RECV: begin
        if (held_msgs.size() == 0) begin
          res.status = pmq_pkg::ST_EMPTY;
        end else begin
          msg = held_msgs.pop_front();
          res.status = pmq_pkg::ST_OK;
          res.out_payload = msg.data;
          res.out_size = msg.size;
          res.out_priority = msg.prio;
        end
      end
      pmq_pkg::FUNC_CLEAR: begin
        held_msgs.delete();
        res.status = pmq_pkg::ST_OK;
      end
      default: begin
        res.status = pmq_pkg::ST_BADPAR;
      end
    endcase
    res.occupancy = 5'(held_msgs.size());
    return res;
  endfunction

  function automatic pmq_pkg::in_item_t send_op(logic [7:0] prio, logic [3:0] size,
                                                logic [63:0] data);
    pmq_pkg::in_item_t op;
    op.func = pmq_pkg::FUNC_SEND;
    op.payload = data;
    op.msg_size = size;
    op.priority_req = prio;
    return op;
  endfunction

  // Non-send operations carry random junk in the unused fields.
  function automatic pmq_pkg::in_item_t other_op(logic [1:0] func);
    pmq_pkg::in_item_t op;
    op.func = func;
    op.payload = {$urandom, $urandom};
    op.msg_size = 4'($urandom_range(0, 15));
    op.priority_req = 8'($urandom_range(0, 255));
    return op;
  endfunction

  task automatic queue_op(pmq_pkg::in_item_t op);
    pending_ops.push_back(op);
    items_queued++;
  endtask

  task automatic queue_random_ops(int count, int send_pct);
    int roll;
    int prio_hi;
    int size_hi;
    logic [7:0] prio;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      size_hi = (max_size_reg < pmq_pkg::PAYLOAD_BYTES_DEF) ? max_size_reg
                                                            : pmq_pkg::PAYLOAD_BYTES_DEF;
      if (roll < send_pct) begin
        if (max_prio_reg == 8'd0) begin
          prio = 8'($urandom_range(0, 255));
        end else begin
          // Half the sends draw from a few priorities so that ties are common.
          prio_hi = (max_prio_reg < 4) ? max_prio_reg : 4;
          prio = $urandom_range(0, 1) ? 8'($urandom_range(1, prio_hi))
                                      : 8'($urandom_range(1, max_prio_reg));
        end
        queue_op(send_op(prio, 4'($urandom_range(0, size_hi)), {$urandom, $urandom}));
      end else if (roll < 94) begin
        queue_op(other_op(pmq_pkg::FUNC_RECV));
      end else if (roll < 96) begin
        queue_op(other_op(pmq_pkg::FUNC_CLEAR));
      end else if (roll < 98) begin
        queue_op(send_op(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                         {$urandom, $urandom}));
      end else begin
        queue_op(other_op(FUNC_UNUSED));
      end
    end
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    unique case (idx)
      pmq_pkg::CFG_CAPACITY:     capacity_reg = value[4:0];
      pmq_pkg::CFG_MAX_PRIORITY: max_prio_reg = value;
      pmq_pkg::CFG_MAX_SIZE:     max_size_reg = value[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] cap, logic [7:0] prio, logic [7:0] size);
    write_reg(pmq_pkg::CFG_CAPACITY, cap);
    write_reg(pmq_pkg::CFG_MAX_PRIORITY, prio);
    write_reg(pmq_pkg::CFG_MAX_SIZE, size);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration.
    queue_op(other_op(pmq_pkg::FUNC_RECV));
    queue_op(send_op(8'd255, 4'd15, {64{1'b1}}));
    pending_ops[$].func = FUNC_UNUSED;
    queue_op(send_op(8'd0, 4'd4, {$urandom, $urandom}));
    queue_op(send_op(8'd10, 4'd9, {$urandom, $urandom}));
    queue_op(send_op(8'd10, 4'd15, {$urandom, $urandom}));
    queue_op(send_op(8'd255, 4'd8, {64{1'b1}}));
    queue_op(send_op(8'd1, 4'd0, {64{1'b1}}));
    queue_op(send_op(8'd1, 4'd3, {$urandom, $urandom}));
    queue_op(send_op(8'd128, 4'd8, 64'd0));
    queue_op(send_op(8'd128, 4'd5, 64'hA5A5_5A5A_F00F_0FF0));
    repeat (6) queue_op(other_op(pmq_pkg::FUNC_RECV));
    queue_op(send_op(8'd7, 4'd1, {$urandom, $urandom}));
    queue_op(send_op(8'd3, 4'd2, {$urandom, $urandom}));
    queue_op(send_op(8'd7, 4'd6, {$urandom, $urandom}));
    queue_op(other_op(pmq_pkg::FUNC_CLEAR));
    queue_op(other_op(pmq_pkg::FUNC_RECV));
    queue_op(send_op(8'd2, 4'd4, {$urandom, $urandom}));
    queue_op(other_op(pmq_pkg::FUNC_RECV));
    wait_drained();

    // Reset configuration, with one long receiver stall while the sender keeps offering items.
    stall_requests++;
    queue_random_ops(200, 55);
    // Fill up so that the next, smaller capacity starts below the occupancy.
    for (int n = 0; n < 16; n++) begin
      queue_op(send_op(8'($urandom_range(1, 255)), 4'($urandom_range(0, 8)),
                       {$urandom, $urandom}));
    end
    wait_drained();

    set_config(8'd4, 8'd3, 8'd2);
    queue_random_ops(120, 50);
    wait_drained();

    set_config(8'd0, 8'd255, 8'd0);
    queue_random_ops(40, 60);
    wait_drained();

    // Capacity and size above what the storage holds; the unused index must be ignored.
    set_config(8'd31, 8'd1, 8'd15);
    write_reg(CFG_UNUSED, 8'hFF);
    queue_random_ops(120, 55);
    wait_drained();

    set_config(8'd16, 8'd0, 8'd8);
    queue_random_ops(30, 60);
    wait_drained();

    set_config(8'd10, 8'd255, 8'd8);
    no_idle = 1'b1;
    stall_requests++;
    queue_random_ops(150, 50);
    wait_drained();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    logic offer;
    pmq_pkg::in_item_t next_op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_queue_op(in_data));
        items_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_ops.size() != 0) begin
          next_op = pending_ops.pop_front();
          in_data <= next_op;
          offer = 1'b1;
          tx_wait = no_idle ? 0 : $urandom_range(0, 3);
        end
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : monitor
    pmq_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload, out_data.out_payload);
            mismatches++;
          end
          if (out_data.out_size !== want.out_size) begin
            $error("out_size: expected %0d, got %0d", want.out_size, out_data.out_size);
            mismatches++;
          end
          if (out_data.out_priority !== want.out_priority) begin
            $error("out_priority: expected %0d, got %0d", want.out_priority,
                   out_data.out_priority);
            mismatches++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_data.occupancy);
            mismatches++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_served != stall_requests) begin
        stall_served++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
